// ----- rtl/pip_pkg.sv -----
// shared types and constants for the point-in-polygon test block
`timescale 1ns / 1ps

package pip_pkg;

    // polygon table depth
    localparam int MAX_VERTICES = 256;

    // ring position counter and effective vertex count widths
    localparam int STEP_W = $clog2(MAX_VERTICES);
    localparam int NUM_W  = $clog2(MAX_VERTICES + 1);

    // field widths
    localparam int COORD_W = 16;
    localparam int COUNT_W = 9;
    localparam int INDEX_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 2'd2;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // one stored vertex
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vertex;

    // one edge handed to the edge test unit: c is the current vertex, d the one before
    typedef struct packed {
        logic    valid;
        t_vertex c;
        t_vertex d;
    } t_edge_req;

endpackage

// ----- rtl/pip_vertex_cell.sv -----
// one cell of the vertex ring: holds a vertex, loads by index or from its neighbor
`timescale 1ns / 1ps

module pip_vertex_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  logic             i_wr_en,
    input  pip_pkg::t_vertex i_wr_vtx,
    input  pip_pkg::t_vertex i_nb_vtx,
    output pip_pkg::t_vertex o_vtx
);

    pip_pkg::t_vertex r_vtx;

    // rotate along the ring, or take a vertex write addressed to this slot
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_vtx <= i_nb_vtx;
        end else if (i_wr_en) begin
            r_vtx <= i_wr_vtx;
        end
    end

    assign o_vtx = r_vtx;

endmodule

// ----- rtl/pip_edge_unit.sv -----
// pipelined crossing test for one polygon edge per cycle with a running parity
`timescale 1ns / 1ps

module pip_edge_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clear,
    input  pip_pkg::t_edge_req                  i_edge,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_px,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_py,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_off_x,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_off_y,
    output logic                                o_parity
);

    localparam int S_W = pip_pkg::COORD_W + 1;
    localparam int D_W = pip_pkg::COORD_W + 2;
    localparam int P_W = 2 * D_W;

    // stage 1: translated vertices
    logic                  r_v1;
    logic signed [S_W-1:0] r_xc, r_yc, r_xd, r_yd;
    // stage 2: straddle flag and differences
    logic                  r_v2;
    logic signed [D_W-1:0] r_a, r_b, r_e, r_dy;
    // stage 3: cross products
    logic                  r_v3;
    logic                  r_dy_pos;
    logic signed [P_W-1:0] r_lhs, r_rhs;
    // parity of crossings
    logic                  r_parity;

    logic signed [S_W-1:0] w_px, w_py;
    logic                  w_straddle;
    logic                  w_left;

    assign w_px = $signed({i_px[pip_pkg::COORD_W-1], i_px});
    assign w_py = $signed({i_py[pip_pkg::COORD_W-1], i_py});
    assign w_straddle = (r_yc > w_py) != (r_yd > w_py);
    assign w_left = r_dy_pos ? (r_lhs < r_rhs) : (r_lhs > r_rhs);

    // control: valid bits and parity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_parity <= 1'b0;
        end else begin
            r_v1 <= i_edge.valid;
            r_v2 <= r_v1 && w_straddle;
            r_v3 <= r_v2;
            if (i_clear) begin
                r_parity <= 1'b0;
            end else if (r_v3 && w_left) begin
                r_parity <= !r_parity;
            end
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_xc <= $signed({i_edge.c.x[pip_pkg::COORD_W-1], i_edge.c.x})
              + $signed({i_off_x[pip_pkg::COORD_W-1], i_off_x});
        r_yc <= $signed({i_edge.c.y[pip_pkg::COORD_W-1], i_edge.c.y})
              + $signed({i_off_y[pip_pkg::COORD_W-1], i_off_y});
        r_xd <= $signed({i_edge.d.x[pip_pkg::COORD_W-1], i_edge.d.x})
              + $signed({i_off_x[pip_pkg::COORD_W-1], i_off_x});
        r_yd <= $signed({i_edge.d.y[pip_pkg::COORD_W-1], i_edge.d.y})
              + $signed({i_off_y[pip_pkg::COORD_W-1], i_off_y});

        r_a  <= $signed({w_px[S_W-1], w_px}) - $signed({r_xc[S_W-1], r_xc});
        r_b  <= $signed({r_xd[S_W-1], r_xd}) - $signed({r_xc[S_W-1], r_xc});
        r_e  <= $signed({w_py[S_W-1], w_py}) - $signed({r_yc[S_W-1], r_yc});
        r_dy <= $signed({r_yd[S_W-1], r_yd}) - $signed({r_yc[S_W-1], r_yc});

        // dy is nonzero on a straddling edge, so a clear sign bit means positive
        r_lhs    <= r_a * r_dy;
        r_rhs    <= r_b * r_e;
        r_dy_pos <= !r_dy[D_W-1];
    end

    assign o_parity = r_parity;

endmodule

// ----- rtl/point_in_polygon_test.sv -----
// top level of the point-in-polygon test block: vertex ring, sequencer, config
`timescale 1ns / 1ps

// Input channel (i_in_valid / o_in_stall) carries one beat per command.
// A write beat (command 0) stores coord_x/coord_y at vertex_index
// and gives no result. A query beat (command 1) gives one output beat
// on o_out_valid / i_out_stall with o_inside_res set when the point lies
// inside the polygon (even-odd rule over the first vertex_count vertices,
// each shifted by offset_x/offset_y).
// A query rotates the 256-cell vertex ring once past the edge test unit,
// one edge per cycle, then closes the polygon and drains the 4-stage edge
// pipeline before the result is loaded. The rotation always covers all
// 256 cells, whatever vertex_count holds.
// o_in_stall stays high from query accept until the result is loaded into
// the output register; write beats are taken while a result still waits.
// If the receiver stalls, the result holds in the output register and a
// finished query waits until that register is free.
// Configuration writes (i_cfg_we) take effect at once; reset sets
// vertex_count to 256 and both offsets to 0. The vertex table is not
// cleared by reset and has to be written before use.

module point_in_polygon_test (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_command,
    input  logic [pip_pkg::INDEX_W-1:0]           i_vertex_index,
    input  logic signed [pip_pkg::COORD_W-1:0]    i_coord_x,
    input  logic signed [pip_pkg::COORD_W-1:0]    i_coord_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_inside_res,
    input  logic                                  i_cfg_we,
    input  logic [pip_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pip_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int N = pip_pkg::MAX_VERTICES;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_CLOSE = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [1:0] DRAIN_LAST = 2'd2;
    localparam logic [pip_pkg::STEP_W-1:0] STEP_LAST = pip_pkg::STEP_W'(N - 1);

    // control registers
    logic [2:0]                   r_state;
    logic [pip_pkg::STEP_W-1:0]   r_step;
    logic [1:0]                   r_drain;
    logic                         r_out_valid;
    logic                         r_out_res;

    // configuration
    logic [pip_pkg::COUNT_W-1:0]          r_vertex_count;
    logic signed [pip_pkg::COORD_W-1:0]   r_offset_x;
    logic signed [pip_pkg::COORD_W-1:0]   r_offset_y;

    // query payload
    logic signed [pip_pkg::COORD_W-1:0]   r_px, r_py;
    pip_pkg::t_vertex                     r_prev, r_first, r_last;

    logic                         w_in_acc;
    logic                         w_query;
    logic                         w_write;
    logic                         w_shift;
    logic                         w_load_out;
    logic [pip_pkg::NUM_W-1:0]    w_num;
    logic [pip_pkg::NUM_W-1:0]    w_step_ext;
    logic                         w_parity;
    pip_pkg::t_vertex             w_vtx [N];
    pip_pkg::t_vertex             w_wr_vtx;
    pip_pkg::t_edge_req           w_edge;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_query    = w_in_acc && (i_command == pip_pkg::CMD_QUERY);
    assign w_write    = w_in_acc && (i_command == pip_pkg::CMD_WRITE);
    assign w_shift    = (r_state == ST_RUN);
    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    assign w_wr_vtx   = '{x: i_coord_x, y: i_coord_y};

    // vertices in use, limited to the table depth
    assign w_num = (int'(r_vertex_count) > N) ? pip_pkg::NUM_W'(N)
                                              : pip_pkg::NUM_W'(r_vertex_count);
    assign w_step_ext = pip_pkg::NUM_W'(r_step);

    // vertex ring: cell g takes from cell g+1, cell 0 is the head
    for (genvar g = 0; g < N; g++) begin : g_ring
        localparam int NB = (g + 1) % N;
        pip_vertex_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_shift),
            .i_wr_en  (w_write && (int'(i_vertex_index) == g)),
            .i_wr_vtx (w_wr_vtx),
            .i_nb_vtx (w_vtx[NB]),
            .o_vtx    (w_vtx[g])
        );
    end

    // edge selection: consecutive edges while rotating, closing edge after
    always_comb begin
        w_edge = '{valid: 1'b0, c: w_vtx[0], d: r_prev};
        if (r_state == ST_RUN) begin
            w_edge.valid = (r_step != '0) && (w_step_ext < w_num);
        end else if (r_state == ST_CLOSE) begin
            w_edge.valid = (w_num != '0);
            w_edge.c     = r_first;
            w_edge.d     = r_last;
        end
    end

    pip_edge_unit u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_query),
        .i_edge   (w_edge),
        .i_px     (r_px),
        .i_py     (r_py),
        .i_off_x  (r_offset_x),
        .i_off_y  (r_offset_y),
        .o_parity (w_parity)
    );

    // sequencer and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_step <= '0;
                    if (w_query) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_LAST) begin
                        r_state <= ST_CLOSE;
                    end
                end
                ST_CLOSE: begin
                    r_drain <= '0;
                    r_state <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    r_drain <= r_drain + 1'b1;
                    if (r_drain == DRAIN_LAST) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= pip_pkg::COUNT_W'(N);
            r_offset_x     <= '0;
            r_offset_y     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pip_pkg::CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data[pip_pkg::COUNT_W-1:0];
                pip_pkg::CFG_OFFSET_X:     r_offset_x     <= $signed(i_cfg_data);
                pip_pkg::CFG_OFFSET_Y:     r_offset_y     <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // query point, vertex history and result payload
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (r_state == ST_RUN) begin
            r_prev <= w_vtx[0];
            if (r_step == '0) begin
                r_first <= w_vtx[0];
            end
            if (w_step_ext == w_num - 1'b1) begin
                r_last <= w_vtx[0];
            end
        end
        if (w_load_out) begin
            r_out_res <= w_parity;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_res;

endmodule

// ----- verif/point_in_polygon_test_test.sv -----
// self-checking testbench for the point-in-polygon test block
`timescale 1ns / 1ps

module point_in_polygon_test_test;
    import pip_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_ITEMS = 300;
    localparam int CALM_FROM    = 250;
    localparam int LONG_HOLD    = 1500;
    localparam int SETTLE       = 8;
    localparam int TAIL         = 300;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t C_MIN = 16'sh8000;
    localparam coord_t C_MAX = 16'sh7FFF;

    // tracks the polygon table and registers, predicts the inside flag of each query
    class crossing_scoreboard;
        coord_t             x_table [MAX_VERTICES];
        coord_t             y_table [MAX_VERTICES];
        logic [COUNT_W-1:0] vertex_count;
        coord_t             shift_x;
        coord_t             shift_y;
        bit                 expected_flags [$];
        int                 mismatches;
        int                 queries;
        int                 insides;
        int                 vertex_writes;
        int                 reg_writes;

        function new();
            vertex_count  = COUNT_W'(MAX_VERTICES);
            shift_x       = '0;
            shift_y       = '0;
            mismatches    = 0;
            queries       = 0;
            insides       = 0;
            vertex_writes = 0;
            reg_writes    = 0;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("mismatch: %s", msg);
        endtask

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_VERTEX_COUNT: vertex_count = data[COUNT_W-1:0];
                CFG_OFFSET_X:     shift_x = coord_t'(data);
                CFG_OFFSET_Y:     shift_y = coord_t'(data);
                default: ;
            endcase
            reg_writes++;
        endfunction

        // even-odd crossing rule with the division turned into a signed cross product
        function bit crossing_parity(coord_t px, coord_t py);
            int     n;
            int     d;
            longint qx, qy, xc, yc, xd, yd, dy, lhs, rhs;
            bit     odd;
            bit     left;
            n = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
            qx = longint'(px);
            qy = longint'(py);
            odd = 1'b0;
            if (n == 0)
                return 1'b0;
            d = n - 1;
            for (int c = 0; c < n; c++) begin
                xc = longint'(x_table[c]) + longint'(shift_x);
                yc = longint'(y_table[c]) + longint'(shift_y);
                xd = longint'(x_table[d]) + longint'(shift_x);
                yd = longint'(y_table[d]) + longint'(shift_y);
                if ((yc > qy) != (yd > qy)) begin
                    dy  = yd - yc;
                    lhs = (qx - xc) * dy;
                    rhs = (xd - xc) * (qy - yc);
                    left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
                    if (left)
                        odd = ~odd;
                end
                d = c;
            end
            return odd;
        endfunction

        // one accepted input beat
        function void note_beat(logic cmd, logic [INDEX_W-1:0] index, coord_t x, coord_t y);
            bit flag;
            if (cmd == CMD_WRITE) begin
                x_table[index] = x;
                y_table[index] = y;
                vertex_writes++;
            end else begin
                flag = crossing_parity(x, y);
                expected_flags = {expected_flags, flag};
                queries++;
                if (flag)
                    insides++;
            end
        endfunction

        // one accepted output beat
        task check_flag(logic flag);
            bit want;
            if (expected_flags.size() == 0) begin
                report($sformatf("inside_res %0b with no query pending", flag));
            end else begin
                want = expected_flags.pop_front();
                if (flag !== want)
                    report($sformatf("inside_res got %0b want %0b", flag, want));
            end
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_command;
    logic [INDEX_W-1:0]      i_vertex_index;
    coord_t                  i_coord_x;
    coord_t                  i_coord_y;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_inside_res;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    crossing_scoreboard board;
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int holds_wanted = 0;
    int holds_served = 0;
    int cycles       = 0;

    point_in_polygon_test dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_inside_res   (o_inside_res),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("point_in_polygon_test_test NOT OK");
            $finish;
        end
    end

    // output beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_flag(o_inside_res);
    end

    // receiver stall: random bursts, plus long hold-offs on request
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (holds_served != holds_wanted) begin
                holds_served++;
                stall_left = LONG_HOLD - 1;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < out_idle_pct) begin
                stall_left = $urandom_range(0, 6);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic coord_t clamp16(longint v);
        if (v > 32767)
            return C_MAX;
        if (v < -32768)
            return C_MIN;
        return coord_t'(v);
    endfunction

    function automatic coord_t near(longint centre, int span);
        return clamp16(centre + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic coord_t pick_shift();
        case ($urandom_range(0, 4))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            default: return near(0, 1 << $urandom_range(4, 15));
        endcase
    endfunction

    // one input beat, with an optional idle burst ahead of it
    task automatic send_beat(input logic cmd, input logic [INDEX_W-1:0] index,
                             input coord_t x, input coord_t y);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_vertex_index <= index;
        i_coord_x      <= x;
        i_coord_y      <= y;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        board.note_beat(cmd, index, x, y);
    endtask

    task automatic put_vertex(input int index, input coord_t x, input coord_t y);
        send_beat(CMD_WRITE, INDEX_W'(index), x, y);
    endtask

    task automatic ask(input coord_t x, input coord_t y);
        send_beat(CMD_QUERY, INDEX_W'($urandom), x, y);
    endtask

    // wait until every pending query has answered and the block is quiet
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (board.expected_flags.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write all three registers back to back
    task automatic apply_setting(input logic [CFG_DATA_W-1:0] count_word,
                                 input coord_t shift_x, input coord_t shift_y);
        logic [CFG_IDX_W-1:0]  regs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        regs = '{CFG_VERTEX_COUNT, CFG_OFFSET_X, CFG_OFFSET_Y};
        vals = '{count_word, shift_x, shift_y};
        for (int i = 0; i < 3; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            board.set_register(regs[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // stimulus
    initial begin
        int                 random_items;
        int                 phase;
        int                 n_used;
        int                 n_put;
        int                 n_queries;
        int                 span;
        int                 j;
        int                 r;
        logic [COUNT_W-1:0] count;
        coord_t             ox, oy, vcx, vcy, pcx, pcy, qx, qy;

        board = new();
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_command      <= CMD_WRITE;
        i_vertex_index <= '0;
        i_coord_x      <= '0;
        i_coord_y      <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_VERTEX_COUNT;
        i_cfg_data     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole table so no query ever reads an unwritten slot
        in_idle_pct  = 20;
        out_idle_pct = 20;
        for (int i = 0; i < MAX_VERTICES; i++)
            put_vertex(i, coord_t'($urandom), coord_t'($urandom));

        // full table at reset count, extreme query points
        ask(16'sd0, 16'sd0);
        ask(C_MIN, C_MAX);

        // square: inside, outside, on a vertex, on the edges
        quiesce();
        apply_setting(16'd4, 16'sd0, 16'sd0);
        put_vertex(0, -16'sd100, -16'sd100);
        put_vertex(1, 16'sd100, -16'sd100);
        put_vertex(2, 16'sd100, 16'sd100);
        put_vertex(3, -16'sd100, 16'sd100);
        ask(16'sd0, 16'sd0);
        ask(16'sd200, 16'sd0);
        ask(-16'sd100, -16'sd100);
        ask(16'sd100, 16'sd0);
        ask(-16'sd100, 16'sd0);
        ask(16'sd0, 16'sd100);

        // extreme vertices with extreme offsets: sums past 16 bits
        quiesce();
        apply_setting(16'd4, C_MAX, C_MIN);
        put_vertex(0, C_MIN, C_MIN);
        put_vertex(1, C_MAX, C_MIN);
        put_vertex(2, C_MAX, C_MAX);
        put_vertex(3, C_MIN, C_MAX);
        ask(C_MAX, C_MIN);
        ask(16'sd0, -16'sd100);
        ask(C_MIN, C_MAX);

        // counts below three and above the table
        quiesce();
        apply_setting(16'd0, 16'sd0, 16'sd0);
        ask(-16'sd50, 16'sd0);
        quiesce();
        apply_setting(16'd1, 16'sd0, 16'sd0);
        ask(16'sd0, 16'sd0);
        quiesce();
        apply_setting(16'd2, 16'sd0, 16'sd0);
        ask(16'sd0, 16'sd0);
        quiesce();
        apply_setting(16'hFFFF, 16'sd0, 16'sd0);
        ask(16'sd0, 16'sd0);

        // random phases: a fresh polygon per setting, then queries around it
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            quiesce();
            if (random_items >= CALM_FROM) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                out_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            end
            r = $urandom_range(0, 19);
            case (r)
                0:       count = COUNT_W'(MAX_VERTICES);
                1:       count = COUNT_W'(MAX_VERTICES - 1);
                2:       count = COUNT_W'($urandom_range(0, 2));
                3:       count = COUNT_W'($urandom_range(MAX_VERTICES + 1, 511));
                4, 5, 6: count = COUNT_W'($urandom_range(13, 40));
                default: count = COUNT_W'($urandom_range(3, 12));
            endcase
            ox = pick_shift();
            oy = pick_shift();
            span = 1 << $urandom_range(2, 15);
            vcx = near(0, 32767);
            vcy = near(0, 32767);
            pcx = clamp16(longint'(vcx) + longint'(ox));
            pcy = clamp16(longint'(vcy) + longint'(oy));
            apply_setting({7'($urandom), count}, ox, oy);

            n_used = (count > MAX_VERTICES) ? MAX_VERTICES : int'(count);
            n_put  = (n_used > 48) ? 48 : n_used;
            for (int i = 0; i < n_put; i++) begin
                put_vertex(i, near(vcx, span), near(vcy, span));
                random_items++;
            end

            // once, hold the receiver off long enough for the block to back up
            if (phase == 2)
                holds_wanted++;

            n_queries = $urandom_range(6, 20);
            for (int k = 0; k < n_queries; k++) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    put_vertex($urandom_range(0, MAX_VERTICES - 1),
                               near(vcx, span), near(vcy, span));
                end else if (r < 15) begin
                    put_vertex($urandom_range(0, MAX_VERTICES - 1),
                               coord_t'($urandom), coord_t'($urandom));
                end else if (r < 65) begin
                    ask(near(pcx, span), near(pcy, span));
                end else if (r < 85) begin
                    // on or level with a shifted vertex
                    j  = $urandom_range(0, (n_put > 0) ? n_put - 1 : 0);
                    qx = clamp16(longint'(board.x_table[j]) + longint'(ox));
                    qy = clamp16(longint'(board.y_table[j]) + longint'(oy));
                    case ($urandom_range(0, 2))
                        0: ask(qx, qy);
                        1: ask(near(pcx, span), qy);
                        default: ask(qx, near(pcy, span));
                    endcase
                end else begin
                    ask(coord_t'($urandom), coord_t'($urandom));
                end
                random_items++;
            end
            phase++;
        end

        // drain and let the pipeline run out
        i_in_valid <= 1'b0;
        while (board.expected_flags.size() != 0)
            @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        if (board.expected_flags.size() != 0)
            board.report($sformatf("%0d queries never answered", board.expected_flags.size()));
        $display("ran %0d queries (%0d expected inside) and %0d vertex writes",
                 board.queries, board.insides, board.vertex_writes);
        $display("%0d register writes over %0d phases, counts 0..511, offsets at both ends",
                 board.reg_writes, phase);
        if (board.mismatches == 0) begin
            $display("point_in_polygon_test_test OK");
        end else begin
            $display("point_in_polygon_test_test NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pip_pkg.sv
rtl/pip_vertex_cell.sv
rtl/pip_edge_unit.sv
rtl/point_in_polygon_test.sv
verif/point_in_polygon_test_test.sv
